// ===== src/snp_pkg.sv =====
package snp_pkg;

	// Protocol states of the node
	typedef enum logic [3:0] {
		ST_WAIT_INIT,
		ST_WAIT_TYPE,
		ST_WAIT_DHI,
		ST_WAIT_DLO,
		ST_WAIT_COUNT,
		ST_INIT_DATA,
		ST_WAIT_POLL,
		ST_WAIT_POLL_END,
		ST_WAIT_DELAY,
		ST_SENDING,
		ST_WAIT_XMIT,
		ST_XMIT_DATA
	} state_t;

	typedef enum logic [2:0] {
		OP_INIT,
		OP_POLL,
		OP_RECV_STEP,
		OP_XMIT,
		OP_END_FRAME,
		OP_DATA,
		OP_TICK,
		OP_LOAD_SENSE
	} op_t;

	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_REPLY_BEGIN = 3'd1;
	localparam logic [2:0] EV_HOST_BYTE  = 3'd2;
	localparam logic [2:0] EV_SET_BYTE   = 3'd3;
	localparam logic [2:0] EV_OUT_BYTE   = 3'd4;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_PROTOCOL = 3'd1;
	localparam logic [2:0] ERR_TYPE     = 3'd2;
	localparam logic [2:0] ERR_COUNT    = 3'd3;
	localparam logic [2:0] ERR_OVERFLOW = 3'd4;

	localparam logic [1:0] CFG_NODE_ADDR  = 2'd0;
	localparam logic [1:0] CFG_NODE_TYPE  = 2'd1;
	localparam logic [1:0] CFG_SENSE_CNT  = 2'd2;

	// Byte position must reach 256 when the output store is 256 deep
	localparam int POS_W = 9;

	// Result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [7:0] index;
		logic       pending;
		logic [2:0] err;
	} res_t;

endpackage

// ===== src/serial_node_protocol_fsm_top.sv =====
// Channel   Handshake                Payload
// -------   ----------------------   ------------------------------------------------
// input     in_valid / in_ready      operation, data_value, sense_index
// result    out_valid / out_ready    event_kind, event_byte, event_index,
//                                    reply_pending, error_code
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle is sustained while out_ready stays high; each input
// transaction yields exactly one result, which passes the capture stage and the queue.
// The front stage updates the protocol state in the accept cycle; the sense-store
// read and result capture sit in one stage, then a four-entry result queue.
// in_ready drops only when the queue plus the stage in flight would fill it, so a
// stalled result consumer never loses a transaction. Config is always ready.
// Reset clears protocol state, counters, registers and the sense-store valid bits.
module serial_node_protocol_fsm_top #(
	parameter int SENSE_BYTES  = 32,
	parameter int OUTPUT_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// input transactions
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [7:0] data_value,
	input  logic [4:0] sense_index,
	// result transactions
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] event_byte,
	output logic [7:0] event_index,
	output logic       reply_pending,
	output logic [2:0] error_code,
	// configuration writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int SAW = (SENSE_BYTES > 1) ? $clog2(SENSE_BYTES) : 1;

	logic                          accept;
	logic                          s1_valid;
	snp_pkg::res_t                 s1_res;
	logic                          s1_use_sense;
	logic                          sense_wr_en;
	logic [SAW-1:0]                sense_wr_addr;
	logic [7:0]                    sense_wr_data;
	logic [SAW-1:0]                sense_rd_addr;
	logic [7:0]                    sense_rd_data;
	snp_pkg::res_t                 push_res;
	snp_pkg::res_t                 head;
	logic [snp_pkg::QCNT_W-1:0]    q_count;
	logic [snp_pkg::QCNT_W-1:0]    q_used;

	// Reserve a queue slot for the transaction still in the capture stage
	assign q_used    = q_count + {{(snp_pkg::QCNT_W-1){1'b0}}, s1_valid};
	assign in_ready  = (q_used < snp_pkg::QCNT_W'(snp_pkg::QDEPTH - 1));
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	snp_front #(
		.SENSE_BYTES (SENSE_BYTES),
		.OUTPUT_BYTES(OUTPUT_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.data_value   (data_value),
		.sense_index  (sense_index),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s1_valid     (s1_valid),
		.s1_res       (s1_res),
		.s1_use_sense (s1_use_sense),
		.sense_wr_en  (sense_wr_en),
		.sense_wr_addr(sense_wr_addr),
		.sense_wr_data(sense_wr_data),
		.sense_rd_addr(sense_rd_addr)
	);

	// Read the sense store on every accepted transaction; the data lines up with s1
	snp_sense_mem #(
		.DEPTH(SENSE_BYTES)
	) u_sense_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && sense_wr_en),
		.wr_addr(sense_wr_addr),
		.wr_data(sense_wr_data),
		.rd_en  (accept),
		.rd_addr(sense_rd_addr),
		.rd_data(sense_rd_data)
	);

	// Merge the sense byte into host-byte results
	always_comb begin
		push_res = s1_res;
		if (s1_use_sense) begin
			push_res.data = sense_rd_data;
		end
	end

	snp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s1_valid),
		.push_data(push_res),
		.pop      (out_valid && out_ready),
		.not_empty(out_valid),
		.head     (head),
		.count    (q_count)
	);

	assign event_kind    = head.kind;
	assign event_byte    = head.data;
	assign event_index   = head.index;
	assign reply_pending = head.pending;
	assign error_code    = head.err;

endmodule

// ===== src/snp_sense_mem.sv =====
module snp_sense_mem #(
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [7:0]                            wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [7:0]                            rd_data
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 8'd0;

endmodule

// ===== src/snp_queue.sv =====
module snp_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  snp_pkg::res_t                 push_data,
	input  logic                          pop,
	output logic                          not_empty,
	output snp_pkg::res_t                 head,
	output logic [snp_pkg::QCNT_W-1:0]    count
);

	snp_pkg::res_t                  slot_q [snp_pkg::QDEPTH];
	logic [snp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [snp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [snp_pkg::QCNT_W-1:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign count     = cnt_q;

endmodule

// ===== src/snp_front.sv =====
module snp_front #(
	parameter int SENSE_BYTES  = 32,
	parameter int OUTPUT_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [2:0]          operation,
	input  logic [7:0]          data_value,
	input  logic [4:0]          sense_index,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output logic                s1_valid,
	output snp_pkg::res_t       s1_res,
	output logic                s1_use_sense,
	output logic                sense_wr_en,
	output logic [(SENSE_BYTES > 1 ? $clog2(SENSE_BYTES) : 1)-1:0] sense_wr_addr,
	output logic [7:0]          sense_wr_data,
	output logic [(SENSE_BYTES > 1 ? $clog2(SENSE_BYTES) : 1)-1:0] sense_rd_addr
);

	localparam int SAW = (SENSE_BYTES > 1) ? $clog2(SENSE_BYTES) : 1;
	localparam logic [snp_pkg::POS_W-1:0] SENSE_LIM = snp_pkg::POS_W'(SENSE_BYTES);
	localparam logic [snp_pkg::POS_W-1:0] OUT_LIM   = snp_pkg::POS_W'(OUTPUT_BYTES);

	snp_pkg::state_t             state_q, nxt_state;
	logic [15:0]                 delay_q, nxt_delay;
	logic [7:0]                  setc_q, nxt_setc;
	logic [snp_pkg::POS_W-1:0]   pos_q, nxt_pos;
	logic [15:0]                 ticks_q, nxt_ticks;
	logic [7:0]                  addr_q;
	logic [7:0]                  type_q;
	logic [5:0]                  scnt_q;

	snp_pkg::op_t                op;
	snp_pkg::res_t               res;
	logic                        use_sense;
	logic [snp_pkg::POS_W-1:0]   scnt_w;
	logic [snp_pkg::POS_W-1:0]   send_lim;
	logic                        delay_done;
	logic                        send_more;
	logic                        set_more;
	logic                        out_room;
	logic                        set_full;
	logic                        type_ok;
	logic                        idx_ok;

	assign op         = snp_pkg::op_t'(operation);
	assign scnt_w     = {3'b000, scnt_q};
	assign send_lim   = (scnt_w > SENSE_LIM) ? SENSE_LIM : scnt_w;
	assign delay_done = (ticks_q >= delay_q);
	assign send_more  = (pos_q < send_lim);
	assign set_more   = (pos_q < {1'b0, setc_q});
	assign set_full   = (pos_q == {1'b0, setc_q});
	assign out_room   = (pos_q < OUT_LIM);
	assign type_ok    = (data_value == type_q);
	assign idx_ok     = ({4'b0000, sense_index} < SENSE_LIM);

	// Next protocol state
	always_comb begin
		nxt_state = state_q;
		case (op)
			snp_pkg::OP_INIT: begin
				if (state_q == snp_pkg::ST_WAIT_INIT) nxt_state = snp_pkg::ST_WAIT_TYPE;
			end
			snp_pkg::OP_POLL: begin
				if (state_q == snp_pkg::ST_WAIT_POLL) nxt_state = snp_pkg::ST_WAIT_POLL_END;
			end
			snp_pkg::OP_RECV_STEP: begin
				if (state_q == snp_pkg::ST_WAIT_DELAY && delay_done) begin
					nxt_state = snp_pkg::ST_SENDING;
				end else if (state_q == snp_pkg::ST_SENDING && !send_more) begin
					nxt_state = snp_pkg::ST_WAIT_XMIT;
				end
			end
			snp_pkg::OP_XMIT: begin
				if (state_q == snp_pkg::ST_WAIT_XMIT) nxt_state = snp_pkg::ST_XMIT_DATA;
			end
			snp_pkg::OP_END_FRAME: begin
				case (state_q)
					snp_pkg::ST_INIT_DATA: begin
						if (set_full) nxt_state = snp_pkg::ST_WAIT_POLL;
					end
					snp_pkg::ST_WAIT_POLL_END: nxt_state = snp_pkg::ST_WAIT_DELAY;
					snp_pkg::ST_XMIT_DATA:     nxt_state = snp_pkg::ST_WAIT_POLL;
					default:                   nxt_state = state_q;
				endcase
			end
			snp_pkg::OP_DATA: begin
				case (state_q)
					snp_pkg::ST_WAIT_TYPE: begin
						if (type_ok) nxt_state = snp_pkg::ST_WAIT_DHI;
					end
					snp_pkg::ST_WAIT_DHI:   nxt_state = snp_pkg::ST_WAIT_DLO;
					snp_pkg::ST_WAIT_DLO:   nxt_state = snp_pkg::ST_WAIT_COUNT;
					snp_pkg::ST_WAIT_COUNT: nxt_state = snp_pkg::ST_INIT_DATA;
					default:                nxt_state = state_q;
				endcase
			end
			default: nxt_state = state_q;
		endcase
	end

	// Datapath updates and result
	always_comb begin
		nxt_delay     = delay_q;
		nxt_setc      = setc_q;
		nxt_pos       = pos_q;
		nxt_ticks     = ticks_q;
		res           = '0;
		use_sense     = 1'b0;
		sense_wr_en   = 1'b0;
		case (op)
			snp_pkg::OP_INIT: begin
				if (state_q != snp_pkg::ST_WAIT_INIT) res.err = snp_pkg::ERR_PROTOCOL;
			end
			snp_pkg::OP_POLL: begin
				if (state_q != snp_pkg::ST_WAIT_POLL) res.err = snp_pkg::ERR_PROTOCOL;
			end
			snp_pkg::OP_RECV_STEP: begin
				res.pending = 1'b1;
				if (state_q == snp_pkg::ST_WAIT_DELAY) begin
					if (delay_done) begin
						nxt_pos  = '0;
						res.kind = snp_pkg::EV_REPLY_BEGIN;
						res.data = addr_q;
					end
				end else if (state_q == snp_pkg::ST_SENDING) begin
					if (send_more) begin
						nxt_pos   = pos_q + 1'b1;
						res.kind  = snp_pkg::EV_HOST_BYTE;
						res.index = pos_q[7:0];
						use_sense = 1'b1;
					end else begin
						res.pending = 1'b0;
					end
				end else begin
					res.err = snp_pkg::ERR_PROTOCOL;
				end
			end
			snp_pkg::OP_XMIT: begin
				if (state_q == snp_pkg::ST_WAIT_XMIT) begin
					nxt_pos = '0;
				end else begin
					res.err = snp_pkg::ERR_PROTOCOL;
				end
			end
			snp_pkg::OP_END_FRAME: begin
				case (state_q)
					snp_pkg::ST_INIT_DATA: begin
						if (!set_full) res.err = snp_pkg::ERR_COUNT;
					end
					snp_pkg::ST_WAIT_POLL_END: nxt_ticks = '0;
					snp_pkg::ST_XMIT_DATA:     res.err   = snp_pkg::ERR_NONE;
					default:                   res.err   = snp_pkg::ERR_PROTOCOL;
				endcase
			end
			snp_pkg::OP_DATA: begin
				case (state_q)
					snp_pkg::ST_WAIT_TYPE: begin
						if (!type_ok) res.err = snp_pkg::ERR_TYPE;
					end
					snp_pkg::ST_WAIT_DHI: nxt_delay = {data_value, 8'd0};
					snp_pkg::ST_WAIT_DLO: nxt_delay = delay_q | {8'd0, data_value};
					snp_pkg::ST_WAIT_COUNT: begin
						nxt_setc = data_value;
						nxt_pos  = '0;
					end
					snp_pkg::ST_INIT_DATA: begin
						if (set_more) begin
							nxt_pos   = pos_q + 1'b1;
							res.kind  = snp_pkg::EV_SET_BYTE;
							res.data  = data_value;
							res.index = pos_q[7:0];
						end else begin
							res.err = snp_pkg::ERR_PROTOCOL;
						end
					end
					snp_pkg::ST_XMIT_DATA: begin
						if (out_room) begin
							nxt_pos   = pos_q + 1'b1;
							res.kind  = snp_pkg::EV_OUT_BYTE;
							res.data  = data_value;
							res.index = pos_q[7:0];
						end else begin
							res.err = snp_pkg::ERR_OVERFLOW;
						end
					end
					default: res.err = snp_pkg::ERR_PROTOCOL;
				endcase
			end
			snp_pkg::OP_TICK: begin
				if (ticks_q != 16'hFFFF) nxt_ticks = ticks_q + 16'd1;
			end
			snp_pkg::OP_LOAD_SENSE: begin
				sense_wr_en = idx_ok;
			end
			default: res = '0;
		endcase
	end

	assign sense_wr_addr = SAW'(sense_index);
	assign sense_wr_data = data_value;
	assign sense_rd_addr = pos_q[SAW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= snp_pkg::ST_WAIT_INIT;
			delay_q  <= '0;
			setc_q   <= '0;
			pos_q    <= '0;
			ticks_q  <= '0;
			addr_q   <= '0;
			type_q   <= '0;
			scnt_q   <= '0;
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
			if (accept) begin
				state_q <= nxt_state;
				delay_q <= nxt_delay;
				setc_q  <= nxt_setc;
				pos_q   <= nxt_pos;
				ticks_q <= nxt_ticks;
			end
			if (cfg_we) begin
				case (cfg_index)
					snp_pkg::CFG_NODE_ADDR: addr_q <= cfg_data;
					snp_pkg::CFG_NODE_TYPE: type_q <= cfg_data;
					snp_pkg::CFG_SENSE_CNT: scnt_q <= cfg_data[5:0];
					default:                addr_q <= addr_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_res       <= res;
			s1_use_sense <= use_sense;
		end
	end

endmodule

// ===== tb/tb_serial_node_protocol_fsm_top.sv =====
class serial_node_tracker;
	localparam int SENSE_N  = 32;
	localparam int OUTPUT_N = 32;

	logic [7:0]      node_addr;
	logic [7:0]      node_kind;
	logic [5:0]      sense_cnt;
	snp_pkg::state_t phase;
	logic [15:0]     reply_wait;
	logic [15:0]     ticks;
	logic [7:0]      set_cnt;
	int unsigned     pos;
	logic [7:0]      sense_mem [SENSE_N];
	logic [7:0]      out_mem [OUTPUT_N];
	snp_pkg::res_t   due_results [$];
	int unsigned     results_seen;
	int              mismatches;

	function new();
		node_addr    = '0;
		node_kind    = '0;
		sense_cnt    = '0;
		phase        = snp_pkg::ST_WAIT_INIT;
		reply_wait   = '0;
		ticks        = '0;
		set_cnt      = '0;
		pos          = 0;
		results_seen = 0;
		mismatches   = 0;
		foreach (sense_mem[i]) sense_mem[i] = '0;
		foreach (out_mem[i]) out_mem[i] = '0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [7:0] v);
		case (idx)
			snp_pkg::CFG_NODE_ADDR: node_addr = v;
			snp_pkg::CFG_NODE_TYPE: node_kind = v;
			snp_pkg::CFG_SENSE_CNT: sense_cnt = v[5:0];
			default: ;
		endcase
	endfunction

	function void take_event(snp_pkg::op_t op, logic [7:0] b, logic [4:0] si);
		snp_pkg::res_t r;
		int unsigned   run;
		r   = '0;
		run = (sense_cnt > SENSE_N) ? SENSE_N : sense_cnt;
		case (op)
			snp_pkg::OP_INIT: begin
				if (phase == snp_pkg::ST_WAIT_INIT) phase = snp_pkg::ST_WAIT_TYPE;
				else r.err = snp_pkg::ERR_PROTOCOL;
			end
			snp_pkg::OP_POLL: begin
				if (phase == snp_pkg::ST_WAIT_POLL) phase = snp_pkg::ST_WAIT_POLL_END;
				else r.err = snp_pkg::ERR_PROTOCOL;
			end
			snp_pkg::OP_RECV_STEP: begin
				r.pending = 1'b1;
				if (phase == snp_pkg::ST_WAIT_DELAY) begin
					if (ticks >= reply_wait) begin
						phase  = snp_pkg::ST_SENDING;
						pos    = 0;
						r.kind = snp_pkg::EV_REPLY_BEGIN;
						r.data = node_addr;
					end
				end else if (phase == snp_pkg::ST_SENDING) begin
					if (pos < run) begin
						r.kind  = snp_pkg::EV_HOST_BYTE;
						r.data  = sense_mem[pos];
						r.index = 8'(pos);
						pos++;
					end else begin
						phase     = snp_pkg::ST_WAIT_XMIT;
						r.pending = 1'b0;
					end
				end else begin
					r.err = snp_pkg::ERR_PROTOCOL;
				end
			end
			snp_pkg::OP_XMIT: begin
				if (phase == snp_pkg::ST_WAIT_XMIT) begin
					phase = snp_pkg::ST_XMIT_DATA;
					pos   = 0;
				end else begin
					r.err = snp_pkg::ERR_PROTOCOL;
				end
			end
			snp_pkg::OP_END_FRAME: begin
				case (phase)
					snp_pkg::ST_INIT_DATA: begin
						if (pos == set_cnt) phase = snp_pkg::ST_WAIT_POLL;
						else r.err = snp_pkg::ERR_COUNT;
					end
					snp_pkg::ST_WAIT_POLL_END: begin
						ticks = '0;
						phase = snp_pkg::ST_WAIT_DELAY;
					end
					snp_pkg::ST_XMIT_DATA: phase = snp_pkg::ST_WAIT_POLL;
					default: r.err = snp_pkg::ERR_PROTOCOL;
				endcase
			end
			snp_pkg::OP_DATA: begin
				case (phase)
					snp_pkg::ST_WAIT_TYPE: begin
						if (b == node_kind) phase = snp_pkg::ST_WAIT_DHI;
						else r.err = snp_pkg::ERR_TYPE;
					end
					snp_pkg::ST_WAIT_DHI: begin
						reply_wait = {b, 8'h00};
						phase      = snp_pkg::ST_WAIT_DLO;
					end
					snp_pkg::ST_WAIT_DLO: begin
						reply_wait = reply_wait | {8'h00, b};
						phase      = snp_pkg::ST_WAIT_COUNT;
					end
					snp_pkg::ST_WAIT_COUNT: begin
						set_cnt = b;
						pos     = 0;
						phase   = snp_pkg::ST_INIT_DATA;
					end
					snp_pkg::ST_INIT_DATA: begin
						if (pos < set_cnt) begin
							r.kind  = snp_pkg::EV_SET_BYTE;
							r.data  = b;
							r.index = 8'(pos);
							pos++;
						end else begin
							r.err = snp_pkg::ERR_PROTOCOL;
						end
					end
					snp_pkg::ST_XMIT_DATA: begin
						if (pos < OUTPUT_N) begin
							out_mem[pos] = b;
							r.kind       = snp_pkg::EV_OUT_BYTE;
							r.data       = b;
							r.index      = 8'(pos);
							pos++;
						end else begin
							r.err = snp_pkg::ERR_OVERFLOW;
						end
					end
					default: r.err = snp_pkg::ERR_PROTOCOL;
				endcase
			end
			snp_pkg::OP_TICK: begin
				if (ticks != 16'hFFFF) ticks++;
			end
			default: begin
				if (si < SENSE_N) sense_mem[si] = b;
			end
		endcase
		due_results.push_back(r);
	endfunction

	function void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void match_result(snp_pkg::res_t got);
		snp_pkg::res_t want;
		results_seen++;
		if (due_results.size() == 0) begin
			$error("result transaction with no input outstanding");
			mismatches++;
			return;
		end
		want = due_results.pop_front();
		check_field("event_kind", 8'(want.kind), 8'(got.kind));
		check_field("event_byte", want.data, got.data);
		check_field("event_index", want.index, got.index);
		check_field("reply_pending", 8'(want.pending), 8'(got.pending));
		check_field("error_code", 8'(want.err), 8'(got.err));
	endfunction
endclass

module tb_serial_node_protocol_fsm_top;
	timeunit 1ns;
	timeprecision 1ps;

	// index 3 decodes to no register; the block must ignore it
	localparam logic [1:0] CFG_SPARE     = 2'd3;
	// reply delay programmed by the one init frame of the run
	localparam logic [7:0] REPLY_WAIT_HI = 8'h00;
	localparam logic [7:0] REPLY_WAIT_LO = 8'h06;
	localparam int         REPLY_WAIT    = 6;
	localparam int         RANDOM_ITEMS  = 720;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] operation;
	logic [7:0] data_value;
	logic [4:0] sense_index;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] event_kind;
	logic [7:0] event_byte;
	logic [7:0] event_index;
	logic       reply_pending;
	logic [2:0] error_code;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	serial_node_tracker sb;

	int          burst_left = 0;  // transactions left in the current sender burst
	int unsigned issued     = 0;  // input transactions accepted so far
	int          sense_run  = 0;  // sense bytes per reply under the current settings
	logic [15:0] stall_pat  = '1;
	int          pat_left   = 0;

	serial_node_protocol_fsm_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.data_value   (data_value),
		.sense_index  (sense_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.event_byte   (event_byte),
		.event_index  (event_index),
		.reply_pending(reply_pending),
		.error_code   (error_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: rotate a stall pattern and swap it for a fresh one now and then.
	// Some patterns are all ones, giving long stretches with no back-pressure; bit 0
	// is always forced high so the consumer never stalls for a whole lap.
	always @(posedge clk) begin
		if (pat_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;
				1: stall_pat = 16'($urandom);
				2: stall_pat = 16'($urandom | $urandom);
				default: stall_pat = 16'($urandom & $urandom);
			endcase
			stall_pat[0] = 1'b1;
			pat_left     = $urandom_range(32, 256);
		end else begin
			pat_left--;
		end
		out_ready <= stall_pat[0];
		stall_pat  = {stall_pat[0], stall_pat[15:1]};
	end

	// Sample every handshake on the clock edge, before the block's own updates land.
	// Predict first so that a result can never overtake its own transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.take_event(snp_pkg::op_t'(operation), data_value, sense_index);
			if (out_valid && out_ready)
				sb.match_result(snp_pkg::res_t'({event_kind, event_byte, event_index,
					reply_pending, error_code}));
		end
	end

	// Offer one input transaction and hold it until it is taken. Transactions go out
	// in bursts; between bursts valid drops for a random gap.
	task automatic send_event(input snp_pkg::op_t op, input logic [7:0] b,
		input logic [4:0] si);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		operation   <= op;
		data_value  <= b;
		sense_index <= si;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		issued++;
	endtask

	task automatic send_noise();
		send_event(snp_pkg::op_t'($urandom_range(0, 7)), 8'($urandom), 5'($urandom));
	endtask

	// Drop valid and hold off until every transaction has produced its result, then
	// let the pipeline go quiet before touching the registers.
	task automatic drain();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (sb.results_seen < issued) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four register indexes back to back, the unused one included.
	task automatic configure(input logic [7:0] addr, input logic [7:0] kind,
		input logic [7:0] cnt, input logic [7:0] spare);
		logic [1:0] idx [4];
		logic [7:0] val [4];
		idx = '{snp_pkg::CFG_NODE_ADDR, snp_pkg::CFG_NODE_TYPE, snp_pkg::CFG_SENSE_CNT,
			CFG_SPARE};
		val = '{addr, kind, cnt, spare};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		// only six bits are kept, and the reply length clamps at the store size
		sense_run = (cnt[5:0] > 6'd32) ? 32 : int'(cnt[5:0]);
	endtask

	// One poll / reply / transmit round with random content. Now and then the round
	// is broken: stray transactions, a missing end of frame, a reply cut short or
	// overrun, or too many output bytes. The protocol recovers within a round.
	task automatic poll_round(input int tick_cnt);
		int steps;
		int n_out;
		repeat ($urandom_range(0, 3))
			send_event(snp_pkg::OP_LOAD_SENSE, 8'($urandom), 5'($urandom));
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) send_noise();
		send_event(snp_pkg::OP_POLL, 8'($urandom), 5'($urandom));
		if ($urandom_range(0, 19) != 0)
			send_event(snp_pkg::OP_END_FRAME, 8'($urandom), 5'($urandom));
		repeat (tick_cnt) send_event(snp_pkg::OP_TICK, 8'($urandom), 5'($urandom));
		// too early: ask for the reply before the delay has run out, then top it up
		if (tick_cnt < REPLY_WAIT) begin
			repeat ($urandom_range(1, 2))
				send_event(snp_pkg::OP_RECV_STEP, 8'($urandom), 5'($urandom));
			repeat (REPLY_WAIT - tick_cnt)
				send_event(snp_pkg::OP_TICK, 8'($urandom), 5'($urandom));
		end
		// reply header, the sense bytes, then the step that closes the reply
		steps = sense_run + 2;
		case ($urandom_range(0, 9))
			0: steps = $urandom_range(0, steps - 1);
			1: steps++;
			default: ;
		endcase
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_event(snp_pkg::OP_LOAD_SENSE, 8'($urandom), 5'($urandom));
			send_event(snp_pkg::OP_RECV_STEP, 8'($urandom), 5'($urandom));
		end
		send_event(snp_pkg::OP_XMIT, 8'($urandom), 5'($urandom));
		n_out = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 32);
		repeat (n_out) send_event(snp_pkg::OP_DATA, 8'($urandom), 5'($urandom));
		send_event(snp_pkg::OP_END_FRAME, 8'($urandom), 5'($urandom));
	endtask

	initial begin
		int unsigned random_base;
		int unsigned budget;
		int          lap;
		int          k;
		logic [7:0]  addr;
		logic [7:0]  cnt;

		sb          = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = snp_pkg::OP_INIT;
		data_value  = '0;
		sense_index = '0;
		cfg_valid   = 1'b0;
		cfg_index   = snp_pkg::CFG_NODE_ADDR;
		cfg_data    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		configure(8'hA5, 8'h3C, 8'd4, 8'hFF);

		// Directed: every operation out of turn, the sense store ends, then an init
		// frame with a wrong type byte, the largest set count and an early end.
		send_event(snp_pkg::OP_RECV_STEP, 8'h00, 5'd0);
		send_event(snp_pkg::OP_POLL, 8'hFF, 5'd31);
		send_event(snp_pkg::OP_XMIT, 8'h00, 5'd0);
		send_event(snp_pkg::OP_END_FRAME, 8'hFF, 5'd31);
		send_event(snp_pkg::OP_DATA, 8'hFF, 5'd0);
		send_event(snp_pkg::OP_TICK, 8'h00, 5'd31);
		send_event(snp_pkg::OP_LOAD_SENSE, 8'hFF, 5'd31);
		send_event(snp_pkg::OP_LOAD_SENSE, 8'h00, 5'd0);
		send_event(snp_pkg::OP_LOAD_SENSE, 8'h81, 5'd1);
		send_event(snp_pkg::OP_INIT, 8'h00, 5'd0);
		send_event(snp_pkg::OP_INIT, 8'hFF, 5'd31);
		send_event(snp_pkg::OP_DATA, 8'h00, 5'd0);
		send_event(snp_pkg::OP_DATA, 8'h3C, 5'd0);
		send_event(snp_pkg::OP_DATA, REPLY_WAIT_HI, 5'd0);
		send_event(snp_pkg::OP_DATA, REPLY_WAIT_LO, 5'd0);
		send_event(snp_pkg::OP_POLL, 8'h00, 5'd0);
		send_event(snp_pkg::OP_DATA, 8'hFF, 5'd0);
		send_event(snp_pkg::OP_DATA, 8'h00, 5'd0);
		send_event(snp_pkg::OP_DATA, 8'hFF, 5'd0);
		send_event(snp_pkg::OP_END_FRAME, 8'h00, 5'd0);
		send_event(snp_pkg::OP_RECV_STEP, 8'hFF, 5'd31);

		// Random: finish the set bytes, one more past the count, close the init frame
		random_base = issued;
		repeat (253) send_event(snp_pkg::OP_DATA, 8'($urandom), 5'($urandom));
		send_event(snp_pkg::OP_DATA, 8'($urandom), 5'($urandom));
		send_event(snp_pkg::OP_END_FRAME, 8'($urandom), 5'($urandom));

		drain();
		configure(8'h00, 8'hFF, 8'd63, 8'h00);

		// Poll rounds, with the registers rewritten between some of them
		lap = 0;
		budget = RANDOM_ITEMS;
		while (issued - random_base < budget) begin
			if (lap != 0 && $urandom_range(0, 3) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: addr = 8'h00;
					1: addr = 8'hFF;
					default: addr = 8'($urandom);
				endcase
				case ($urandom_range(0, 5))
					0: cnt = 8'd0;
					1: cnt = 8'd32;
					2: cnt = 8'd63;
					3: cnt = 8'($urandom_range(33, 255));
					default: cnt = 8'($urandom_range(1, 8));
				endcase
				configure(addr, 8'($urandom), cnt, 8'($urandom));
			end
			poll_round($urandom_range(0, 9));
			lap++;
		end

		// Wind down: wait for the tail of results, bounded, then a few quiet cycles
		in_valid <= 1'b0;
		for (k = 0; k < 20000 && sb.results_seen < issued; k++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.due_results.size() != 0) begin
			$error("%0d expected results never arrived", sb.due_results.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Hard stop well beyond the slowest legitimate run
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
